@@ sv/deq_pkg.sv @@
// Shared types, constants and helpers for the deferred extent queue.
// Used by deferred_extent_queue_top and deq_checker; no dependencies.
package deq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int PEND_W      = 37;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_TAKE  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] start_block;
    logic [15:0] owner_tag;
    logic [31:0] block_count;
  } req_t;

  typedef struct packed {
    logic [47:0]       out_start;
    logic [31:0]       piece_len;
    logic [15:0]       out_owner;
    logic [1:0]        status;
    logic [PEND_W-1:0] pending_blocks;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [47:0] start;
    logic [31:0] length;
    logic [15:0] owner;
  } entry_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

endpackage

@@ sv/deferred_extent_queue_top.sv @@
// Deferred extent queue: a ring of freed extents kept in one RAM, with take and flush walks.
// Depends on deq_pkg and deq_ram.
//
// A push or an unused mode yields one result beat. A take or flush with work to do first
// reads the head entry from the ring RAM in S_RD, then retires one entry per cycle through
// the single RAM read port; a flush sends its final beat from state S_FIN, since dropped
// owner-zero entries mean the last piece is known only at the end. A take or flush
// emits at most MAX_RESULTS pieces. Any cycle in which a piece must go out while the output
// register is still full holds the walk; a flush walks on past owner-zero entries and past
// its first owned piece. A new item is taken only when the walk is done and the output
// register is free or being drained; no clearing pass follows reset.
module deferred_extent_queue_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output deq_pkg::rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                 state;
  logic [1:0]                 op;
  logic [deq_pkg::IDX_W-1:0]  head;
  logic [deq_pkg::IDX_W-1:0]  tail;
  logic [deq_pkg::OCC_W-1:0]  occ;
  logic [deq_pkg::PEND_W-1:0] pending;
  logic [31:0]                needed;
  logic [deq_pkg::CNT_W-1:0]  npieces;
  logic                       held_valid;
  deq_pkg::rsp_t              held;

  deq_pkg::entry_t            ent;
  deq_pkg::entry_t            wentry;
  logic                       we;
  logic [deq_pkg::IDX_W-1:0]  waddr;
  logic [deq_pkg::IDX_W-1:0]  raddr;
  logic [deq_pkg::IDX_W-1:0]  head_next;

  logic                       out_free;
  logic                       accept;
  logic                       full;
  logic                       is_take;
  logic                       partial;
  logic                       owns;
  logic                       stall;
  logic                       step;
  logic                       pop;
  logic [31:0]                step_len;
  logic [31:0]                need_after;
  logic [deq_pkg::OCC_W-1:0]  occ_after;
  logic [deq_pkg::PEND_W-1:0] pend_after;
  logic [deq_pkg::PEND_W-1:0] pend_push;
  logic [deq_pkg::CNT_W-1:0]  n_after;
  logic [deq_pkg::CNT_W-1:0]  n_flush;
  logic                       take_done;
  logic                       flush_done;
  deq_pkg::rsp_t              piece;
  deq_pkg::rsp_t              held_last;

  deq_ram #(
    .WIDTH($bits(deq_pkg::entry_t)),
    .DEPTH(deq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wentry),
    .raddr(raddr),
    .rdata(ent)
  );

  always_comb begin
    out_free   = !rsp_valid || rsp_ready;
    req_ready  = (state == S_IDLE) && out_free;
    accept     = req_valid && req_ready;
    full       = (occ == deq_pkg::OCC_W'(deq_pkg::QUEUE_DEPTH));
    pend_push  = pending + {5'b0, req.block_count};

    is_take    = (op == deq_pkg::MODE_TAKE);
    partial    = is_take && (needed < ent.length);
    owns       = (ent.owner != 16'd0);
    step_len   = partial ? needed : ent.length;
    pop        = !partial;
    need_after = needed - step_len;
    occ_after  = pop ? occ - deq_pkg::OCC_W'(1) : occ;
    pend_after = pending - {5'b0, step_len};
    n_after    = npieces + deq_pkg::CNT_W'(1);
    n_flush    = owns ? n_after : npieces;
    take_done  = (need_after == 32'd0) || (occ_after == '0) ||
                 (n_after == deq_pkg::CNT_W'(deq_pkg::MAX_RESULTS));
    flush_done = (occ_after == '0) ||
                 (n_flush == deq_pkg::CNT_W'(deq_pkg::MAX_RESULTS));

    stall      = is_take ? !out_free : (owns && held_valid && !out_free);
    step       = (state == S_EXEC) && !stall;
    head_next  = (step && pop) ? deq_pkg::next_slot(head) : head;
    raddr      = (state == S_EXEC) ? head_next : head;

    piece.out_start      = ent.start;
    piece.piece_len      = step_len;
    piece.out_owner      = ent.owner;
    piece.status         = (is_take && need_after != 32'd0 && occ_after == '0) ?
                           deq_pkg::ST_SHORT : deq_pkg::ST_OK;
    piece.pending_blocks = pend_after;
    piece.last           = is_take && take_done;

    held_last      = held;
    held_last.last = 1'b1;

    if (accept && req.mode == deq_pkg::MODE_PUSH && !full) begin
      we            = 1'b1;
      waddr         = tail;
      wentry.start  = req.start_block;
      wentry.length = req.block_count;
      wentry.owner  = req.owner_tag;
    end else begin
      we            = step && partial;
      waddr         = head;
      wentry.start  = ent.start + {16'd0, needed};
      wentry.length = ent.length - needed;
      wentry.owner  = ent.owner;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      occ        <= '0;
      pending    <= '0;
      needed     <= '0;
      npieces    <= '0;
      rsp_valid  <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op                 <= req.mode;
            npieces            <= '0;
            rsp.out_start      <= '0;
            rsp.piece_len      <= '0;
            rsp.out_owner      <= '0;
            rsp.status         <= deq_pkg::ST_OK;
            rsp.pending_blocks <= pending;
            rsp.last           <= 1'b1;
            case (req.mode)
              deq_pkg::MODE_PUSH: begin
                rsp_valid <= 1'b1;
                if (full) begin
                  rsp.status <= deq_pkg::ST_FULL;
                end else begin
                  tail               <= deq_pkg::next_slot(tail);
                  occ                <= occ + deq_pkg::OCC_W'(1);
                  pending            <= pend_push;
                  rsp.pending_blocks <= pend_push;
                end
              end
              deq_pkg::MODE_TAKE: begin
                needed <= req.block_count;
                if (req.block_count == 32'd0) begin
                  rsp_valid <= 1'b1;
                end else if (occ == '0) begin
                  rsp_valid  <= 1'b1;
                  rsp.status <= deq_pkg::ST_SHORT;
                end else begin
                  state <= S_RD;
                end
              end
              deq_pkg::MODE_FLUSH: begin
                state <= (occ == '0) ? S_FIN : S_RD;
              end
              default: begin
                rsp_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (step) begin
            head    <= head_next;
            occ     <= occ_after;
            pending <= pend_after;
            if (is_take) begin
              needed    <= need_after;
              npieces   <= n_after;
              rsp       <= piece;
              rsp_valid <= 1'b1;
              if (take_done) begin
                state <= S_IDLE;
              end
            end else begin
              npieces <= n_flush;
              if (owns) begin
                held       <= piece;
                held_valid <= 1'b1;
                if (held_valid) begin
                  rsp       <= held;
                  rsp_valid <= 1'b1;
                end
              end
              if (flush_done) begin
                state <= S_FIN;
              end
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp_valid  <= 1'b1;
            held_valid <= 1'b0;
            state      <= S_IDLE;
            if (held_valid) begin
              rsp <= held_last;
            end else begin
              rsp.out_start      <= '0;
              rsp.piece_len      <= '0;
              rsp.out_owner      <= '0;
              rsp.status         <= deq_pkg::ST_OK;
              rsp.pending_blocks <= pending;
              rsp.last           <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/deq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/deq_checker.sv @@
// Port-level checks for deferred_extent_queue_top, attached by bind.
// Depends on deq_pkg.
module deq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input deq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input deq_pkg::rsp_t rsp
);

  // hold a stalled result beat
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  a_full_is_status_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == deq_pkg::ST_FULL |->
      rsp.piece_len == 32'd0 && rsp.out_start == 48'd0 && rsp.out_owner == 16'd0)
    else $error("refused push carries extent data");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == deq_pkg::ST_FULL || rsp.status == deq_pkg::ST_SHORT)
      |-> rsp.last)
    else $error("error status on a beat that is not last");

  a_no_item_during_flush: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.mode == deq_pkg::MODE_FLUSH |=> !req_ready)
    else $error("new item taken while a flush is pending");

endmodule

bind deferred_extent_queue_top deq_checker u_deq_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);

@@ sim/deferred_extent_queue_top_tb.sv @@
// Self-checking testbench for deferred_extent_queue_top: directed and random push, take,
// flush and spare-mode commands with handshake idling on both sides, checked beat by beat
// against an in-bench extent ring. Depends on deq_pkg and the deferred_extent_queue_top RTL.
module deferred_extent_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_CMDS = 350;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  logic          clk;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  deq_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  deq_pkg::rsp_t rsp;

  deferred_extent_queue_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  deq_pkg::req_t cmd_q[$];
  deq_pkg::rsp_t piece_q[$];
  deq_pkg::rsp_t want;

  logic [47:0]                ring_start [deq_pkg::QUEUE_DEPTH];
  logic [31:0]                ring_len   [deq_pkg::QUEUE_DEPTH];
  logic [15:0]                ring_owner [deq_pkg::QUEUE_DEPTH];
  int                         ring_head     = 0;
  int                         ring_tail     = 0;
  int                         ring_fill     = 0;
  logic [deq_pkg::PEND_W-1:0] blocks_queued = '0;
  logic [31:0]                blocks_wanted = '0;

  int errors      = 0;
  int reqs_taken  = 0;
  int beats_seen  = 0;
  int idle_cycles = 0;
  int directed_n  = 0;
  int n_refused   = 0;
  int n_short     = 0;
  int n_split     = 0;
  int n_dropped   = 0;

  int   sent_n     = 0;
  int   send_gap   = 0;
  int   send_pct   = 20;
  logic tail_phase = 1'b0;
  int   hold_left  = 0;
  int   holds_done = 0;
  int   stall_left = 0;
  int   rcv_pct    = 20;
  int   rcv_cyc    = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic deq_pkg::req_t mk_cmd(input logic [1:0] m, input logic [47:0] s,
                                           input logic [15:0] o, input logic [31:0] c);
    deq_pkg::req_t p;
    p.mode        = m;
    p.start_block = s;
    p.owner_tag   = o;
    p.block_count = c;
    return p;
  endfunction

  function automatic deq_pkg::req_t random_push();
    deq_pkg::req_t p;
    logic [63:0]   wide;
    int            pick;
    wide          = {$urandom(), $urandom()};
    p.mode        = deq_pkg::MODE_PUSH;
    p.start_block = wide[47:0];
    pick          = $urandom_range(0, 99);
    if (pick < 20) p.owner_tag = '0;
    else if (pick < 25) p.owner_tag = '1;
    else p.owner_tag = 16'($urandom_range(1, 16'hFFFF));
    pick = $urandom_range(0, 99);
    if (pick < 10) p.block_count = '0;
    else if (pick < 20) p.block_count = $urandom();
    else if (pick < 24) p.block_count = '1;
    else p.block_count = $urandom_range(1, 48);
    return p;
  endfunction

  function automatic deq_pkg::req_t random_take();
    deq_pkg::req_t p;
    logic [63:0]   wide;
    int            pick;
    wide          = {$urandom(), $urandom()};
    p.mode        = deq_pkg::MODE_TAKE;
    p.start_block = wide[63:16];
    p.owner_tag   = wide[15:0];
    pick          = $urandom_range(0, 99);
    if (pick < 8) p.block_count = '0;
    else if (pick < 23) p.block_count = $urandom();
    else if (pick < 28) p.block_count = '1;
    else p.block_count = $urandom_range(1, 64);
    return p;
  endfunction

  function automatic void predict_extent_cmd(input deq_pkg::req_t cmd);
    deq_pkg::rsp_t outs[$];
    deq_pkg::rsp_t r;
    int            h;
    logic [31:0]   len;
    case (cmd.mode)
      deq_pkg::MODE_PUSH: begin
        r        = '0;
        r.status = deq_pkg::ST_FULL;
        if (ring_fill < deq_pkg::QUEUE_DEPTH) begin
          ring_start[ring_tail] = cmd.start_block;
          ring_len[ring_tail]   = cmd.block_count;
          ring_owner[ring_tail] = cmd.owner_tag;
          ring_tail             = (ring_tail + 1) % deq_pkg::QUEUE_DEPTH;
          ring_fill++;
          blocks_queued = blocks_queued + deq_pkg::PEND_W'(cmd.block_count);
          r.status      = deq_pkg::ST_OK;
        end else begin
          n_refused++;
        end
        r.pending_blocks = blocks_queued;
        outs.push_back(r);
      end
      deq_pkg::MODE_TAKE: begin
        blocks_wanted = cmd.block_count;
        while (blocks_wanted != 0 && ring_fill != 0 && outs.size() < deq_pkg::MAX_RESULTS)
        begin
          h           = ring_head;
          len         = ring_len[h];
          r           = '0;
          r.out_start = ring_start[h];
          r.out_owner = ring_owner[h];
          if (blocks_wanted < len) begin
            blocks_queued = blocks_queued - deq_pkg::PEND_W'(blocks_wanted);
            r.piece_len   = blocks_wanted;
            ring_start[h] = ring_start[h] + 48'(blocks_wanted);
            ring_len[h]   = len - blocks_wanted;
            blocks_wanted = '0;
            n_split++;
          end else begin
            blocks_queued = blocks_queued - deq_pkg::PEND_W'(len);
            r.piece_len   = len;
            blocks_wanted = blocks_wanted - len;
            ring_head     = (h + 1) % deq_pkg::QUEUE_DEPTH;
            ring_fill--;
          end
          r.pending_blocks = blocks_queued;
          outs.push_back(r);
        end
        if (blocks_wanted != 0 && ring_fill == 0) begin
          n_short++;
          if (outs.size() == 0) begin
            r                = '0;
            r.status         = deq_pkg::ST_SHORT;
            r.pending_blocks = blocks_queued;
          end else begin
            r        = outs.pop_back();
            r.status = deq_pkg::ST_SHORT;
          end
          outs.push_back(r);
        end
      end
      deq_pkg::MODE_FLUSH: begin
        while (ring_fill != 0 && outs.size() < deq_pkg::MAX_RESULTS) begin
          h             = ring_head;
          len           = ring_len[h];
          blocks_queued = blocks_queued - deq_pkg::PEND_W'(len);
          ring_head     = (h + 1) % deq_pkg::QUEUE_DEPTH;
          ring_fill--;
          if (ring_owner[h] != '0) begin
            r                = '0;
            r.out_start      = ring_start[h];
            r.piece_len      = len;
            r.out_owner      = ring_owner[h];
            r.pending_blocks = blocks_queued;
            outs.push_back(r);
          end else begin
            n_dropped++;
          end
        end
      end
      default: ;
    endcase
    if (outs.size() == 0) begin
      r                = '0;
      r.pending_blocks = blocks_queued;
      outs.push_back(r);
    end
    r      = outs.pop_back();
    r.last = 1'b1;
    outs.push_back(r);
    foreach (outs[i]) piece_q.push_back(outs[i]);
  endfunction

  task automatic report_field(input string what, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      tail_phase <= (cmd_q.size() < 40);
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap  = send_gap - 1;
          req_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          req       <= cmd_q.pop_front();
          req_valid <= 1'b1;
          sent_n++;
          if (sent_n % 32 == 0) begin
            send_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
          end
          if (!tail_phase && hold_left == 0 && $urandom_range(0, 99) < send_pct) begin
            send_gap = $urandom_range(1, 14);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rcv_cyc++;
      if (rcv_cyc % 64 == 0) begin
        rcv_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (holds_done < 2 && reqs_taken >= 60 + 200 * holds_done) begin
        hold_left  <= HOLD_CYCLES;
        holds_done <= holds_done + 1;
        rsp_ready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        rsp_ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 99) < rcv_pct) begin
        stall_left = $urandom_range(0, 13);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        beats_seen <= beats_seen + 1;
        if (piece_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, rsp);
          errors++;
        end else begin
          want = piece_q.pop_front();
          if (rsp.out_start !== want.out_start)
            report_field("out_start", 64'(want.out_start), 64'(rsp.out_start));
          if (rsp.piece_len !== want.piece_len)
            report_field("piece_len", 64'(want.piece_len), 64'(rsp.piece_len));
          if (rsp.out_owner !== want.out_owner)
            report_field("out_owner", 64'(want.out_owner), 64'(rsp.out_owner));
          if (rsp.status !== want.status)
            report_field("status", 64'(want.status), 64'(rsp.status));
          if (rsp.pending_blocks !== want.pending_blocks)
            report_field("pending_blocks", 64'(want.pending_blocks),
                         64'(rsp.pending_blocks));
          if (rsp.last !== want.last)
            report_field("last", 64'(want.last), 64'(rsp.last));
        end
      end
      if (req_valid && req_ready) begin
        predict_extent_cmd(req);
        reqs_taken <= reqs_taken + 1;
      end
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    deq_pkg::req_t p;
    int            pick;
    int            n_rand;
    cmd_q.push_back(mk_cmd(deq_pkg::MODE_TAKE, '0, '0, 32'd5));
    cmd_q.push_back(mk_cmd(deq_pkg::MODE_FLUSH, '0, '0, '0));
    cmd_q.push_back(mk_cmd(deq_pkg::MODE_TAKE, '1, '1, '0));
    cmd_q.push_back(mk_cmd(MODE_SPARE, '1, '1, '1));
    cmd_q.push_back(mk_cmd(deq_pkg::MODE_PUSH, '1, '1, '1));
    cmd_q.push_back(mk_cmd(deq_pkg::MODE_PUSH, 48'h0000_1234_5678, '0, '0));
    cmd_q.push_back(mk_cmd(deq_pkg::MODE_PUSH, '0, 16'h0001, 32'd1));
    cmd_q.push_back(mk_cmd(deq_pkg::MODE_TAKE, '0, '0, 32'd2));
    cmd_q.push_back(mk_cmd(deq_pkg::MODE_TAKE, '0, '0, '1));
    for (int i = 0; i < deq_pkg::QUEUE_DEPTH; i++) begin
      p = random_push();
      if (i % 4 == 1) p.owner_tag = '0;
      cmd_q.push_back(p);
    end
    cmd_q.push_back(random_push());
    cmd_q.push_back(mk_cmd(deq_pkg::MODE_FLUSH, '0, '0, '0));
    directed_n = cmd_q.size();

    n_rand = 0;
    while (n_rand < RANDOM_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        repeat (18) cmd_q.push_back(random_push());
        n_rand += 18;
      end else if (pick < 40) begin
        repeat (8) cmd_q.push_back(random_take());
        n_rand += 8;
      end else begin
        repeat (20) begin
          pick = $urandom_range(0, 99);
          if (pick < 55) begin
            cmd_q.push_back(random_push());
          end else if (pick < 88) begin
            cmd_q.push_back(random_take());
          end else begin
            p      = random_take();
            p.mode = (pick < 96) ? deq_pkg::MODE_FLUSH : MODE_SPARE;
            cmd_q.push_back(p);
          end
        end
        n_rand += 20;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || req_valid || piece_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d commands (%0d directed) and checked %0d result beats.",
             reqs_taken, directed_n, beats_seen);
    $display("Saw %0d refused pushes, %0d short takes, %0d split heads, %0d dropped entries.",
             n_refused, n_short, n_split, n_dropped);
    if (errors == 0 && piece_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/deq_pkg.sv
sv/deq_ram.sv
sv/deferred_extent_queue_top.sv
sv/deq_checker.sv
sim/deferred_extent_queue_top_tb.sv
